/* src/oal_pkg.sv */
// oal_pkg: shared types and codes of the ordered array list engine
// no dependencies; used by the interfaces, the cell, the top level and the checker
`timescale 1ns / 1ps

package oal_pkg;

    localparam int MODE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    localparam logic [MODE_W-1:0] MODE_QUERY     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_REM_AT    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_FIND      = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    // what every cell does with its entry
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_UP   = 2'd1,
        SH_DOWN = 2'd2
    } shift_t;

    typedef struct packed {
        shift_t              shift;
        logic                find_en;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   ins_value;
    } cell_ctrl_t;

endpackage

/* src/oal_req_if.sv */
// oal_req_if: request channel of the ordered array list engine
// depends on oal_pkg for field widths
`timescale 1ns / 1ps

interface oal_req_if;
    logic                               valid;
    logic                               ready;
    logic [oal_pkg::MODE_W-1:0]         mode;
    logic signed [oal_pkg::DATA_W-1:0]  value;
    logic [oal_pkg::POS_W-1:0]          position;

    modport source (output valid, mode, value, position, input ready);
    modport sink (input valid, mode, value, position, output ready);
endinterface

// oal_rsp_if: response channel of the ordered array list engine
interface oal_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [oal_pkg::COUNT_W-1:0]        count;
    logic [oal_pkg::STAT_W-1:0]         status;
    logic                               found;
    logic [oal_pkg::POS_W-1:0]          found_index;
    logic signed [oal_pkg::DATA_W-1:0]  max_value;
    logic [oal_pkg::POS_W-1:0]          max_index;

    modport source (output valid, count, status, found, found_index, max_value, max_index,
                    input ready);
    modport sink (input valid, count, status, found, found_index, max_value, max_index,
                  output ready);
endinterface

/* src/oal_cell.sv */
// oal_cell: one list slot; shifts its entry with its neighbors and
// folds its entry into the find / max wave passing down the chain
// depends on oal_pkg
`timescale 1ns / 1ps

module oal_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7
) (
    input  logic                        clk,
    input  oal_pkg::cell_ctrl_t         ctrl,
    input  logic [IW-1:0]               pos,
    input  logic [CW-1:0]               count,
    input  logic [oal_pkg::DATA_W-1:0]  left_entry,
    input  logic [oal_pkg::DATA_W-1:0]  right_entry,
    output logic [oal_pkg::DATA_W-1:0]  entry,
    input  logic                        prev_found,
    input  logic [IW-1:0]               prev_fidx,
    input  logic [oal_pkg::DATA_W-1:0]  prev_maxv,
    input  logic [IW-1:0]               prev_maxi,
    output logic                        found,
    output logic [IW-1:0]               fidx,
    output logic [oal_pkg::DATA_W-1:0]  maxv,
    output logic [IW-1:0]               maxi
);

    localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
    localparam logic [CW-1:0] MY_SLOT = CW'(IDX);
    localparam bit            IS_HEAD = (IDX == 0);

    logic [oal_pkg::DATA_W-1:0] entry_reg, entry_next;
    logic                       found_reg, found_next;
    logic [IW-1:0]              fidx_reg, fidx_next;
    logic [oal_pkg::DATA_W-1:0] maxv_reg, maxv_next;
    logic [IW-1:0]              maxi_reg, maxi_next;
    logic                       live;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.shift)
            oal_pkg::SH_UP:
            begin
                if (MY_IDX > pos)
                begin
                    entry_next = left_entry;
                end
                else if (MY_IDX == pos)
                begin
                    entry_next = ctrl.ins_value;
                end
            end
            oal_pkg::SH_DOWN:
            begin
                if (MY_IDX >= pos)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // slots at or past the count only pass the wave along
    assign live = (MY_SLOT < count);

    always_comb
    begin
        found_next = prev_found;
        fidx_next  = prev_fidx;
        maxv_next  = prev_maxv;
        maxi_next  = prev_maxi;
        if (live && ctrl.find_en && !prev_found && (entry_reg == ctrl.key))
        begin
            found_next = 1'b1;
            fidx_next  = MY_IDX;
        end
        if (live && (IS_HEAD || ($signed(entry_reg) > $signed(prev_maxv))))
        begin
            maxv_next = entry_reg;
            maxi_next = MY_IDX;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        found_reg <= found_next;
        fidx_reg  <= fidx_next;
        maxv_reg  <= maxv_next;
        maxi_reg  <= maxi_next;
    end

    assign entry = entry_reg;
    assign found = found_reg;
    assign fidx  = fidx_reg;
    assign maxv  = maxv_reg;
    assign maxi  = maxi_reg;

endmodule

/* src/ordered_array_list_engine.sv */
// ordered_array_list_engine: top level; request decode, cell chain, response register
// depends on oal_pkg, oal_req_if, oal_rsp_if and oal_cell
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values held in a row of CAPACITY cells, one entry per
// cell, plus a count. Each request word carries a mode (query, insert front/back/at,
// remove front/back/at, find), a value and a position; each produces one response word
// with the new count, a status (ok, full, empty, position out of range), the find result
// and the largest entry with its first index (0 at 0 on an empty list). Inserts and
// removes move all later entries by one cell in the cycle the request is taken. The find
// and maximum are then computed by a wave that advances one cell per clock down the
// chain. No new request is taken until the result is loaded into the output register;
// the response sits there and a new request may be taken while it waits.
// The store has no reset; only entries below the count are ever reported.
module ordered_array_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    oal_req_if.sink     req,
    oal_rsp_if.source   rsp
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                           state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  scan_cnt_reg, scan_cnt_next;
    logic [oal_pkg::STAT_W-1:0]     status_reg, status_next;
    logic                           find_reg, find_next;
    logic [oal_pkg::DATA_W-1:0]     key_reg, key_next;

    logic                           rsp_valid_reg, rsp_valid_next;
    logic [oal_pkg::COUNT_W-1:0]    rsp_count_reg;
    logic [oal_pkg::STAT_W-1:0]     rsp_status_reg;
    logic                           rsp_found_reg;
    logic [oal_pkg::POS_W-1:0]      rsp_fidx_reg;
    logic [oal_pkg::DATA_W-1:0]     rsp_maxv_reg;
    logic [oal_pkg::POS_W-1:0]      rsp_maxi_reg;

    logic                           accept;
    logic                           out_free;
    logic                           load_rsp;
    logic                           is_full;
    logic                           is_empty;
    logic [CMPW-1:0]                pos_ext;
    logic [CMPW-1:0]                cnt_ext;
    logic [oal_pkg::STAT_W-1:0]     status_now;
    oal_pkg::shift_t                shift_now;
    logic [IW-1:0]                  pos_now;
    logic [CW-1:0]                  count_now;
    oal_pkg::cell_ctrl_t            ctrl;

    logic [oal_pkg::DATA_W-1:0]     entry_w [CAPACITY];
    logic                           found_w [CAPACITY];
    logic [IW-1:0]                  fidx_w  [CAPACITY];
    logic [oal_pkg::DATA_W-1:0]     maxv_w  [CAPACITY];
    logic [IW-1:0]                  maxi_w  [CAPACITY];

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign load_rsp  = (state_reg == S_SCAN) && (scan_cnt_reg == '0) && out_free;

    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_ext  = CMPW'(req.position);
    assign cnt_ext  = CMPW'(count_reg);

    // request decode: status, shift direction, slot and new count
    always_comb
    begin
        status_now = oal_pkg::STAT_OK;
        shift_now  = oal_pkg::SH_HOLD;
        pos_now    = '0;
        count_now  = count_reg;
        unique case (req.mode) inside
            oal_pkg::MODE_INS_FRONT, oal_pkg::MODE_INS_BACK, oal_pkg::MODE_INS_AT:
            begin
                if (is_full)
                begin
                    status_now = oal_pkg::STAT_FULL;
                end
                else if ((req.mode == oal_pkg::MODE_INS_AT) && (pos_ext > cnt_ext))
                begin
                    status_now = oal_pkg::STAT_RANGE;
                end
                else
                begin
                    shift_now = oal_pkg::SH_UP;
                    count_now = count_reg + CW'(1);
                    if (req.mode == oal_pkg::MODE_INS_BACK)
                    begin
                        pos_now = IW'(count_reg);
                    end
                    else if (req.mode == oal_pkg::MODE_INS_AT)
                    begin
                        pos_now = IW'(req.position);
                    end
                end
            end
            oal_pkg::MODE_REM_FRONT, oal_pkg::MODE_REM_BACK, oal_pkg::MODE_REM_AT:
            begin
                if (is_empty)
                begin
                    status_now = oal_pkg::STAT_EMPTY;
                end
                else if ((req.mode == oal_pkg::MODE_REM_AT) && (pos_ext >= cnt_ext))
                begin
                    status_now = oal_pkg::STAT_RANGE;
                end
                else
                begin
                    shift_now = oal_pkg::SH_DOWN;
                    count_now = count_reg - CW'(1);
                    if (req.mode == oal_pkg::MODE_REM_BACK)
                    begin
                        pos_now = IW'(count_reg - CW'(1));
                    end
                    else if (req.mode == oal_pkg::MODE_REM_AT)
                    begin
                        pos_now = IW'(req.position);
                    end
                end
            end
            oal_pkg::MODE_QUERY, oal_pkg::MODE_FIND:
            begin
                status_now = oal_pkg::STAT_OK;
            end
            default:
            begin
                status_now = oal_pkg::STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        status_next    = status_reg;
        find_next      = find_reg;
        key_next       = key_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_SCAN;
                    count_next    = count_now;
                    scan_cnt_next = CW'(CAPACITY);
                    status_next   = status_now;
                    find_next     = (req.mode == oal_pkg::MODE_FIND);
                    key_next      = req.value;
                end
            end
            S_SCAN:
            begin
                // count down while the wave travels down the chain to the tail
                if (scan_cnt_reg != '0)
                begin
                    scan_cnt_next = scan_cnt_reg - CW'(1);
                end
                else if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        find_reg   <= find_next;
        key_reg    <= key_next;
        if (load_rsp)
        begin
            rsp_count_reg  <= oal_pkg::COUNT_W'(count_reg);
            rsp_status_reg <= status_reg;
            rsp_found_reg  <= found_w[CAPACITY-1];
            rsp_fidx_reg   <= oal_pkg::POS_W'(fidx_w[CAPACITY-1]);
            rsp_maxv_reg   <= maxv_w[CAPACITY-1];
            rsp_maxi_reg   <= oal_pkg::POS_W'(maxi_w[CAPACITY-1]);
        end
    end

    assign ctrl.shift     = accept ? shift_now : oal_pkg::SH_HOLD;
    assign ctrl.find_en   = find_reg;
    assign ctrl.key       = key_reg;
    assign ctrl.ins_value = req.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [oal_pkg::DATA_W-1:0] left_entry;
        logic [oal_pkg::DATA_W-1:0] right_entry;
        logic                       prev_found;
        logic [IW-1:0]              prev_fidx;
        logic [oal_pkg::DATA_W-1:0] prev_maxv;
        logic [IW-1:0]              prev_maxi;

        if (i == 0)
        begin : g_head
            assign left_entry = entry_w[i];
            assign prev_found = 1'b0;
            assign prev_fidx  = '0;
            assign prev_maxv  = '0;
            assign prev_maxi  = '0;
        end
        else
        begin : g_body
            assign left_entry = entry_w[i-1];
            assign prev_found = found_w[i-1];
            assign prev_fidx  = fidx_w[i-1];
            assign prev_maxv  = maxv_w[i-1];
            assign prev_maxi  = maxi_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = entry_w[i];
        end
        else
        begin : g_mid
            assign right_entry = entry_w[i+1];
        end

        oal_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .pos         (pos_now),
            .count       (count_reg),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .prev_found  (prev_found),
            .prev_fidx   (prev_fidx),
            .prev_maxv   (prev_maxv),
            .prev_maxi   (prev_maxi),
            .found       (found_w[i]),
            .fidx        (fidx_w[i]),
            .maxv        (maxv_w[i]),
            .maxi        (maxi_w[i])
        );
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.count       = rsp_count_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found       = rsp_found_reg;
    assign rsp.found_index = rsp_fidx_reg;
    assign rsp.max_value   = rsp_maxv_reg;
    assign rsp.max_index   = rsp_maxi_reg;

endmodule

/* src/oal_checker.sv */
// oal_checker: port-level assertions for the ordered array list engine
// depends on oal_pkg; bound to ordered_array_list_engine below
`timescale 1ns / 1ps

module oal_checker #(
    parameter int CAPACITY = 64
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [oal_pkg::COUNT_W-1:0]  rsp_count,
    input logic [oal_pkg::STAT_W-1:0]   rsp_status,
    input logic                         rsp_found,
    input logic [oal_pkg::POS_W-1:0]    rsp_found_index,
    input logic [oal_pkg::DATA_W-1:0]   rsp_max_value,
    input logic [oal_pkg::POS_W-1:0]    rsp_max_index
);

    // a waiting response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status)
            && $stable(rsp_max_value) && $stable(rsp_max_index))
        else $error("response word changed while stalled");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // an empty report leaves an empty list with a zero maximum
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == oal_pkg::STAT_EMPTY) |->
            (rsp_count == '0) && (rsp_max_value == '0) && (rsp_max_index == '0))
        else $error("empty status with nonempty result");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == oal_pkg::STAT_FULL) |->
            (rsp_count == oal_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    // a match lies inside the list; no match reports index zero
    a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            (rsp_found && ((CAPACITY > 64) || (oal_pkg::COUNT_W'(rsp_found_index) < rsp_count)))
            || (!rsp_found && (rsp_found_index == '0)))
        else $error("found index inconsistent with count");

endmodule

bind ordered_array_list_engine oal_checker #(
    .CAPACITY (CAPACITY)
) u_oal_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_count       (rsp.count),
    .rsp_status      (rsp.status),
    .rsp_found       (rsp.found),
    .rsp_found_index (rsp.found_index),
    .rsp_max_value   (rsp.max_value),
    .rsp_max_index   (rsp.max_index)
);
